// ===== rtl/vccf_pkg.sv =====
`default_nettype none

package vccf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 5;
    localparam int EDGE        = 2;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int FW_W  = 11;
    localparam int FH_W  = 13;
    localparam int ROW_W = 13;
    localparam int CFG_W = 13;

    localparam int SCORE_LINES = 4;
    localparam int MASK_LINES  = 2;
    localparam int LANE_W      = $clog2(SCORE_LINES);
    localparam int LINE_WORD_W = SCORE_LINES * SAMPLE_BITS + MASK_LINES;

    localparam int WIN       = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [WIN-1:0][SAMPLE_BITS-1:0] column_t;
    typedef logic [WIN-1:0][WIN-1:0][SAMPLE_BITS-1:0] window_t;

    // one column leaving the line buffers, with its position flags
    typedef struct packed
    {
        logic valid;
        logic emit;
        logic last;
        logic interior;
        logic centre_mask;
    } col_ctrl_t;

    typedef struct packed
    {
        sample_t value;
        logic    last;
    } result_t;

    function automatic sample_t smax(input sample_t a, input sample_t b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    function automatic sample_t smin(input sample_t a, input sample_t b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vein_centre_connection_filter.sv =====
`default_nettype none

// channel   direction  transaction                      payload
// in        input      in_valid && in_ready             kind, centre_score, in_finger
// out       output     out_valid && out_ready           vein_value, frame_end
// cfg       input      cfg_write_en                     cfg_index, cfg_wdata
//
// one item per cycle while in_ready is high; a result is queued before it is offered
// the line memory (one 66-bit word per column) is read on accept, written back in the following cycle
// rst_n clears position, window and queue; line memory holds no reset value, no clearing pass
// in_ready drops only when the 4-entry result queue plus items in flight would overflow
module vein_centre_connection_filter
    import vccf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   kind,
    input  wire logic [SAMPLE_BITS-1:0] centre_score,
    input  wire logic                   in_finger,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [SAMPLE_BITS-1:0] vein_value,
    output logic                        frame_end,
    input  wire logic                   cfg_write_en,
    input  wire logic [0:0]             cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic             accept;
    logic             push, pop;
    col_ctrl_t        ctrl;
    column_t          column;
    result_t          result, head;
    logic [LVL_W-1:0] fifo_level;
    logic [LVL_W:0]   committed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_W'(640);
            frame_height_reg <= FH_W'(480);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // queue slots already promised to results in flight
    assign committed = {1'b0, fifo_level} + (LVL_W+1)'(ctrl.valid) + (LVL_W+1)'(push);
    assign in_ready  = committed < (LVL_W+1)'(FIFO_DEPTH);
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    vccf_lines u_lines (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (kind),
        .centre_score (centre_score),
        .in_finger    (in_finger),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .ctrl         (ctrl),
        .column       (column)
    );

    vccf_connect u_connect (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .column (column),
        .push   (push),
        .result (result)
    );

    vccf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (pop),
        .head      (head),
        .level     (fifo_level)
    );

    assign out_valid  = fifo_level != '0;
    assign vein_value = head.value;
    assign frame_end  = head.last;

    a_accept_reaches_lines: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctrl.valid)
        else $error("accepted item did not reach the line buffer stage");

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_level < LVL_W'(FIFO_DEPTH) || pop))
        else $error("result pushed into a full queue");

    a_silent_item_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.valid && !ctrl.emit) |=> !push)
        else $error("result produced for an item before the first output position");

    a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (fifo_level >= LVL_W'(2)))
        else $error("input stalled without queued results");

endmodule

`default_nettype wire

// ===== rtl/vccf_ram.sv =====
`default_nettype none

module vccf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vccf_lines.sv =====
`default_nettype none

module vccf_lines
    import vccf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              kind,
    input  wire logic [SAMPLE_BITS-1:0] centre_score,
    input  wire logic              in_finger,
    input  wire logic [FW_W-1:0]   frame_width,
    input  wire logic [FH_W-1:0]   frame_height,
    output col_ctrl_t              ctrl,
    output column_t                column
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [FW_W-1:0]  w;
    logic [FH_W-1:0]  h;
    logic [ROW_W-1:0] h_end;
    logic             wrap;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic             last, emit, interior;
    sample_t          score;
    logic             mask;

    logic             s1_valid_reg;
    logic             s1_emit_reg, s1_last_reg, s1_interior_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [LANE_W-1:0] s1_lane_reg;
    sample_t          s1_score_reg;
    logic             s1_mask_reg;
    logic [1:0]       mdelay_reg;

    logic [LINE_WORD_W-1:0] rd_word, wr_word;
    logic             mask_above;

    always_comb
    begin
        priority if (frame_width < FW_W'(MIN_DIM))
            w = FW_W'(MIN_DIM);
        else if (frame_width > FW_W'(MAX_WIDTH))
            w = FW_W'(MAX_WIDTH);
        else
            w = frame_width;
        priority if (frame_height < FH_W'(MIN_DIM))
            h = FH_W'(MIN_DIM);
        else if (frame_height > FH_W'(MAX_HEIGHT))
            h = FH_W'(MAX_HEIGHT);
        else
            h = frame_height;
    end

    assign h_end = ROW_W'(h) + ROW_W'(EDGE);

    // restart the frame when the stored position no longer fits
    assign wrap = ({1'b0, col_reg} >= w) || (row_reg > h_end) ||
                  ((row_reg == h_end) && (col_reg > COL_W'(1)));
    assign c = wrap ? '0 : col_reg;
    assign r = wrap ? '0 : row_reg;

    assign last     = (r == h_end) && (c == COL_W'(1));
    assign emit     = (r > ROW_W'(EDGE)) || ((r == ROW_W'(EDGE)) && (c >= COL_W'(EDGE)));
    assign interior = (c >= COL_W'(2 * EDGE)) && (r >= ROW_W'(2 * EDGE)) &&
                      ({1'b0, r} + (ROW_W+1)'(1) <= (ROW_W+1)'(h));
    assign score    = kind ? '0 : centre_score;
    assign mask     = kind ? 1'b0 : in_finger;

    always_comb
    begin
        if (last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if ({1'b0, c} + FW_W'(1) >= w)
        begin
            col_next = '0;
            row_next = r + ROW_W'(1);
        end
        else
        begin
            col_next = c + COL_W'(1);
            row_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            s1_emit_reg     <= 1'b0;
            s1_last_reg     <= 1'b0;
            s1_interior_reg <= 1'b0;
            mdelay_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg         <= col_next;
                row_reg         <= row_next;
                s1_emit_reg     <= emit;
                s1_last_reg     <= last;
                s1_interior_reg <= interior;
            end
            if (s1_valid_reg)
            begin
                mdelay_reg <= {mdelay_reg[0], mask_above};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= c;
            s1_lane_reg  <= r[LANE_W-1:0];
            s1_score_reg <= score;
            s1_mask_reg  <= mask;
        end
    end

    // word layout: four score lanes, then two mask lanes
    vccf_ram #(
        .WIDTH (LINE_WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (c),
        .rd_data (rd_word)
    );

    assign mask_above = rd_word[SCORE_LINES*SAMPLE_BITS + int'(s1_lane_reg[0])];

    always_comb
    begin
        logic [LANE_W-1:0] idx;
        wr_word = rd_word;
        for (int i = 0; i < SCORE_LINES; i++)
        begin
            idx = LANE_W'(s1_lane_reg + LANE_W'(i));
            column[i] = rd_word[int'(idx)*SAMPLE_BITS +: SAMPLE_BITS];
        end
        column[WIN-1] = s1_score_reg;
        wr_word[int'(s1_lane_reg)*SAMPLE_BITS +: SAMPLE_BITS] = s1_score_reg;
        wr_word[SCORE_LINES*SAMPLE_BITS + int'(s1_lane_reg[0])] = s1_mask_reg;
    end

    always_comb
    begin
        ctrl.valid       = s1_valid_reg;
        ctrl.emit        = s1_emit_reg;
        ctrl.last        = s1_last_reg;
        ctrl.interior    = s1_interior_reg;
        ctrl.centre_mask = mdelay_reg[1];
    end

endmodule

`default_nettype wire

// ===== rtl/vccf_connect.sv =====
`default_nettype none

module vccf_connect
    import vccf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire col_ctrl_t ctrl,
    input  wire column_t   column,
    output logic           push,
    output result_t        result
);

    window_t window_reg, window_next;
    logic    s2_valid_reg, s2_last_reg, s2_use_reg;
    sample_t c1, c2, c3, c4, best;

    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN - 1; j++)
            begin
                window_next[i][j] = window_reg[i][j+1];
            end
            window_next[i][WIN-1] = column[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            s2_use_reg   <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= ctrl.valid && ctrl.emit;
            if (ctrl.valid)
            begin
                window_reg  <= window_next;
                s2_last_reg <= ctrl.last;
                s2_use_reg  <= ctrl.interior && ctrl.centre_mask;
            end
        end
    end

    // window row 0 is the oldest line, column 4 the newest pixel
    always_comb
    begin
        c1 = smin(smax(window_reg[2][3], window_reg[2][4]),
                  smax(window_reg[2][1], window_reg[2][0]));
        c2 = smin(smax(window_reg[3][2], window_reg[4][2]),
                  smax(window_reg[1][2], window_reg[0][2]));
        c3 = smin(smax(window_reg[1][1], window_reg[0][0]),
                  smax(window_reg[3][3], window_reg[4][4]));
        c4 = smin(smax(window_reg[3][1], window_reg[4][0]),
                  smax(window_reg[1][3], window_reg[0][4]));
        best = smax(smax(c1, c2), smax(c3, c4));
    end

    assign push         = s2_valid_reg;
    assign result.value = s2_use_reg ? best : '0;
    assign result.last  = s2_last_reg;

endmodule

`default_nettype wire

// ===== rtl/vccf_fifo.sv =====
`default_nettype none

module vccf_fifo
    import vccf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire result_t  push_data,
    input  wire logic     pop,
    output result_t       head,
    output logic [LVL_W-1:0] level
);

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0]   level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_vein_centre_connection_filter.sv =====
`timescale 1ns / 100ps

module tb_vein_centre_connection_filter;
    import vccf_pkg::*;

    localparam logic        KIND_PIXEL    = 1'b0;
    localparam logic        KIND_DRAIN    = 1'b1;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned RANDOM_ITEMS  = 1000;
    localparam int unsigned DEFAULT_ITEMS = 40;
    localparam int unsigned EDGE_ITEMS    = 60;
    localparam int unsigned FRAME_CAP     = 32'hFFFF_FFFF;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 16;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int          DIRECTED_ROWS = 37;

    typedef enum logic [1:0]
    {
        EXP_NONE,
        EXP_ZERO,
        EXP_LAST,
        EXP_MODEL
    } check_mode_t;

    typedef struct packed
    {
        logic        item_kind;
        sample_t     score;
        logic        finger;
        check_mode_t mode;
    } probe_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   kind         = KIND_PIXEL;
    logic [SAMPLE_BITS-1:0] centre_score = '0;
    logic                   in_finger    = 1'b0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [SAMPLE_BITS-1:0] vein_value;
    logic                   frame_end;
    logic                   cfg_write_en = 1'b0;
    logic [0:0]             cfg_index    = '0;
    logic [CFG_W-1:0]       cfg_wdata    = '0;

    vein_centre_connection_filter u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .centre_score (centre_score),
        .in_finger    (in_finger),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vein_value   (vein_value),
        .frame_end    (frame_end),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one 5x5 frame: 25 pixel positions then 12 drain positions, each part holding one item of the other kind
    probe_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_PIXEL, 16'h7FFF, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'h8000, 1'b0, EXP_NONE},
        '{KIND_PIXEL, 16'h0100, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'hFFFF, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'h5555, 1'b0, EXP_NONE},
        '{KIND_PIXEL, 16'hAAAA, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'h0200, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'h8000, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'h0300, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'h7FFF, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'h0400, 1'b0, EXP_NONE},
        '{KIND_PIXEL, 16'h0180, 1'b1, EXP_NONE},
        '{KIND_PIXEL, 16'h0000, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'h0280, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'hFF00, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'h7FFF, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'h0500, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'hFE00, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'h1234, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'h8000, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'h0080, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'h7FFF, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'h0600, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'hC000, 1'b1, EXP_ZERO},
        '{KIND_PIXEL, 16'h7FFF, 1'b1, EXP_MODEL},
        '{KIND_PIXEL, 16'h7FFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_ZERO},
        '{KIND_DRAIN, 16'hFFFF, 1'b1, EXP_LAST}
    };

    // filter state mirrored on the bench side
    logic signed [SAMPLE_BITS-1:0] score_rows [SCORE_LINES][MAX_WIDTH];
    logic                          mask_rows [MASK_LINES][MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] win_q [WIN][WIN];
    logic                          centre_mask_dly [2];
    int unsigned                   col_pos;
    int unsigned                   row_pos;
    logic [FW_W-1:0]               width_raw;
    logic [FH_W-1:0]               height_raw;

    result_t     expected_pixels [$];
    result_t     oldest;
    int unsigned mismatches     = 0;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;

    task automatic log_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_filter();
        for (int i = 0; i < SCORE_LINES; i++)
            for (int j = 0; j < MAX_WIDTH; j++)
                score_rows[i][j] = '0;
        for (int i = 0; i < MASK_LINES; i++)
            for (int j = 0; j < MAX_WIDTH; j++)
                mask_rows[i][j] = 1'b0;
        for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN; j++)
                win_q[i][j] = '0;
        centre_mask_dly[0] = 1'b0;
        centre_mask_dly[1] = 1'b0;
        col_pos    = 0;
        row_pos    = 0;
        width_raw  = 11'd640;
        height_raw = 13'd480;
    endfunction

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned eff_width();
        return clamp_dim(width_raw, MIN_DIM, MAX_WIDTH);
    endfunction

    function automatic int unsigned eff_height();
        return clamp_dim(height_raw, MIN_DIM, MAX_HEIGHT);
    endfunction

    // the next item starts a new frame when the position no longer fits
    function automatic bit position_restarts(input int unsigned w, input int unsigned h);
        return col_pos >= w || row_pos > h + EDGE || (row_pos == h + EDGE && col_pos > 1);
    endfunction

    function automatic bit next_is_pixel();
        int unsigned r;
        r = position_restarts(eff_width(), eff_height()) ? 0 : row_pos;
        return r < eff_height();
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] larger(
        input logic signed [SAMPLE_BITS-1:0] a, input logic signed [SAMPLE_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] smaller(
        input logic signed [SAMPLE_BITS-1:0] a, input logic signed [SAMPLE_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // each direction: weaker of the two sides, each side the stronger of its two pixels
    function automatic logic signed [SAMPLE_BITS-1:0] connection_strength();
        logic signed [SAMPLE_BITS-1:0] horiz, vert, diag_down, diag_up;
        horiz     = smaller(larger(win_q[2][3], win_q[2][4]), larger(win_q[2][1], win_q[2][0]));
        vert      = smaller(larger(win_q[3][2], win_q[4][2]), larger(win_q[1][2], win_q[0][2]));
        diag_down = smaller(larger(win_q[1][1], win_q[0][0]), larger(win_q[3][3], win_q[4][4]));
        diag_up   = smaller(larger(win_q[3][1], win_q[4][0]), larger(win_q[1][3], win_q[0][4]));
        return larger(larger(horiz, vert), larger(diag_down, diag_up));
    endfunction

    function automatic bit advance_filter(input logic k, input logic [SAMPLE_BITS-1:0] s,
                                          input logic f, output result_t pix);
        int unsigned                   w, h, rr, cc;
        logic signed [SAMPLE_BITS-1:0] score;
        logic signed [SAMPLE_BITS-1:0] column [WIN];
        logic                          mask_bit, centre_mask;
        bit                            emit, last;
        w = eff_width();
        h = eff_height();
        if (position_restarts(w, h))
        begin
            row_pos = 0;
            col_pos = 0;
        end
        rr       = row_pos;
        cc       = col_pos;
        score    = '0;
        mask_bit = 1'b0;
        if (k == KIND_PIXEL)
        begin
            score    = s;
            mask_bit = f;
        end
        for (int i = 0; i < SCORE_LINES; i++)
            column[i] = score_rows[(rr + i) % SCORE_LINES][cc];
        column[WIN-1] = score;
        score_rows[rr % SCORE_LINES][cc] = score;
        // mask of the row two above lines up with the window centre after two more columns
        centre_mask        = centre_mask_dly[1];
        centre_mask_dly[1] = centre_mask_dly[0];
        centre_mask_dly[0] = mask_rows[rr % MASK_LINES][cc];
        mask_rows[rr % MASK_LINES][cc] = mask_bit;
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN - 1; j++)
                win_q[i][j] = win_q[i][j+1];
            win_q[i][WIN-1] = column[i];
        end
        emit = rr > EDGE || (rr == EDGE && cc >= EDGE);
        last = rr == h + EDGE && cc == 1;
        if (cc + 1 >= w)
        begin
            col_pos = 0;
            row_pos = rr + 1;
        end
        else
            col_pos = cc + 1;
        if (last)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        pix.value = '0;
        pix.last  = last;
        if (cc >= 2 * EDGE && rr >= 2 * EDGE && rr + 1 <= h && centre_mask)
            pix.value = connection_strength();
        return emit;
    endfunction

    task automatic send_item(input logic k, input logic [SAMPLE_BITS-1:0] s, input logic f,
                             input check_mode_t mode, output bit closed);
        result_t pix;
        bit      emitted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        centre_score <= s;
        in_finger    <= f;
        do
            @(posedge clk);
        while (!in_ready);
        emitted = advance_filter(k, s, f, pix);
        case (mode)
            EXP_MODEL:
                if (emitted)
                    expected_pixels.push_back(pix);
            EXP_ZERO, EXP_LAST:
                expected_pixels.push_back(result_t'{value: '0, last: mode == EXP_LAST});
            default:
                ;
        endcase
        closed = emitted && pix.last;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_score();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3, 4: return SAMPLE_BITS'($urandom);
            default: return SAMPLE_BITS'($urandom_range(2047) - 1024);
        endcase
    endfunction

    // follows the raster position, with a few items of the wrong kind mixed in
    task automatic run_frame(input int unsigned max_items);
        int unsigned n;
        bit          closed;
        logic        k;
        n      = 0;
        closed = 1'b0;
        while (!closed && n < max_items)
        begin
            k = next_is_pixel() ? KIND_PIXEL : KIND_DRAIN;
            if ($urandom_range(99) < 3)
                k = ~k;
            send_item(k, pick_score(), $urandom_range(99) < 80, EXP_MODEL, closed);
            n++;
        end
        items_sent += n;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_pixels.size() != 0);
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data);
        int unsigned new_w, new_h;
        wait_for_results();
        // items that never produce a result may still be in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
        new_w = clamp_dim(w_data[FW_W-1:0], MIN_DIM, MAX_WIDTH);
        new_h = clamp_dim(h_data, MIN_DIM, MAX_HEIGHT);
        // widening inside a running frame would read line entries never written
        if ((row_pos != 0 || col_pos != 0) && new_w > eff_width() &&
            !position_restarts(new_w, new_h))
            w_data = CFG_W'(width_raw);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_FRAME_WIDTH;
        cfg_wdata    <= w_data;
        @(posedge clk);
        cfg_index    <= REG_FRAME_HEIGHT;
        cfg_wdata    <= h_data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        width_raw  = w_data[FW_W-1:0];
        height_raw = h_data;
    endtask

    function automatic logic [CFG_W-1:0] pick_width();
        logic [CFG_W-1:0] v;
        case ($urandom_range(9))
            0: v = CFG_W'($urandom_range(4));
            1: v = CFG_W'($urandom_range(24, 13));
            default: v = CFG_W'($urandom_range(9, 5));
        endcase
        if ($urandom_range(4) == 0)
            v[CFG_W-1:FW_W] = 2'($urandom_range(3));
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        case ($urandom_range(9))
            0: return CFG_W'($urandom_range(4));
            1: return CFG_W'($urandom_range(14, 9));
            default: return CFG_W'($urandom_range(8, 5));
        endcase
    endfunction

    function automatic void set_idle(input int phase);
        case (phase)
            0:
            begin
                send_gap_pct   = 0;
                sink_stall_pct = 0;
            end
            1:
            begin
                send_gap_pct   = 46;
                sink_stall_pct = 0;
            end
            2:
            begin
                send_gap_pct   = 0;
                sink_stall_pct = 46;
            end
            default:
            begin
                send_gap_pct   = 24;
                sink_stall_pct = 24;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
                log_mismatch($sformatf("unexpected transaction value %h end %b",
                                       vein_value, frame_end));
            else
            begin
                oldest = expected_pixels.pop_front();
                if (vein_value !== oldest.value)
                    log_mismatch($sformatf("vein_value %h, want %h", vein_value, oldest.value));
                if (frame_end !== oldest.last)
                    log_mismatch($sformatf("frame_end %b, want %b", frame_end, oldest.last));
            end
        end
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned stop_at;
        int unsigned n;
        bit          closed;
        clear_filter();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: a few items of the first border row of a 640-wide frame
        set_idle(1);
        run_frame(DEFAULT_ITEMS);

        // zero clamps to the minimum and throws the position out of the frame
        set_geometry('0, '0);
        set_idle(0);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_rows[i].item_kind, directed_rows[i].score,
                      directed_rows[i].finger, directed_rows[i].mode, closed);

        // start of the widest and tallest frames, all-ones data clamps to the maximum
        set_idle(3);
        set_geometry('1, '0);
        run_frame(EDGE_ITEMS);
        set_idle(2);
        set_geometry(13'd5, '1);
        run_frame(EDGE_ITEMS);

        for (int phase = 0; phase < 4; phase++)
        begin
            set_idle(phase);
            stop_at = items_sent + RANDOM_ITEMS / 4;
            // hold the sender mid-frame until the output side has caught up
            run_frame($urandom_range(40, 5));
            wait_for_results();
            while (items_sent < stop_at)
            begin
                if ($urandom_range(1) == 0)
                    set_geometry(pick_width(), pick_height());
                if ($urandom_range(3) == 0)
                    run_frame($urandom_range(60, 1));
                else
                    run_frame(FRAME_CAP);
            end
        end

        in_valid <= 1'b0;
        n = 0;
        do
        begin
            @(negedge clk);
            n++;
        end
        while (expected_pixels.size() != 0 && n < DRAIN_LIMIT);
        if (expected_pixels.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vccf_pkg.sv
rtl/vccf_ram.sv
rtl/vccf_lines.sv
rtl/vccf_connect.sv
rtl/vccf_fifo.sv
rtl/vein_centre_connection_filter.sv
tb/sv/tb_vein_centre_connection_filter.sv
